/* rtl/tle_pkg.sv */
// Shared constants for the terminal line editor: result action codes,
// special byte values and the fixed result field widths.
// No dependencies.
`default_nettype none

package tle_pkg;

  // Result action codes seen by the renderer.
  localparam logic [3:0] ACT_NONE       = 4'd0;
  localparam logic [3:0] ACT_APPEND     = 4'd1;
  localparam logic [3:0] ACT_INSERT_MID = 4'd2;
  localparam logic [3:0] ACT_ERASE_END  = 4'd3;
  localparam logic [3:0] ACT_ERASE_MID  = 4'd4;
  localparam logic [3:0] ACT_LEFT       = 4'd5;
  localparam logic [3:0] ACT_RIGHT      = 4'd6;
  localparam logic [3:0] ACT_RECALL     = 4'd7;
  localparam logic [3:0] ACT_LINE_CHAR  = 4'd8;
  localparam logic [3:0] ACT_OVERFLOW   = 4'd9;
  localparam logic [3:0] ACT_COMPLETE   = 4'd10;
  localparam logic [3:0] ACT_EXIT       = 4'd11;

  // Received byte values with a meaning of their own.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_ESC     = 8'h1b;
  localparam logic [7:0] CH_EXIT    = 8'h1d;
  localparam logic [7:0] CH_BRACKET = 8'h5b;
  localparam logic [7:0] CH_UP      = 8'h41;
  localparam logic [7:0] CH_DOWN    = 8'h42;
  localparam logic [7:0] CH_RIGHT   = 8'h43;
  localparam logic [7:0] CH_LEFT    = 8'h44;
  localparam logic [7:0] CH_DEL     = 8'h7f;

  // Width of the cursor and length fields of a result.
  localparam int POS_W = 6;

endpackage

`default_nettype wire

/* rtl/tle_ifs.sv */
// Request channel interfaces of the terminal line editor: received bytes
// in, editor results out. No dependencies.
`default_nettype none

interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;
  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [7:0] char_value;
  logic [5:0] cursor_pos;
  logic [5:0] line_length;
  logic       echo_flag;
  logic       last_flag;
  modport source (output valid, output action, output char_value, output cursor_pos,
                  output line_length, output echo_flag, output last_flag, input ready);
  modport sink (input valid, input action, input char_value, input cursor_pos,
                input line_length, input echo_flag, input last_flag, output ready);
endinterface

`default_nettype wire

/* rtl/tle_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled. No dependencies.
`default_nettype none

module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/terminal_line_editor_with_history.sv */
// Terminal line editor with history; uses tle_pkg, tle_ifs and tle_ram.
// Most results load on the accepting edge; a right move reads the line in S_RIGHT,
// insert or erase in the middle moves bytes in S_SHIFT, recall copies in S_COPY, and
// each then loads in S_DONE. A line end loads each character via S_DRD and S_DWR,
// then completion in S_DONE. One byte at a time: the next waits for S_IDLE and a free slot.
// Reset (synchronous, rst_n low) clears line, cursor, escape and history state; echo is 1.
`default_nettype none

module terminal_line_editor_with_history #(
  parameter int LINE_SIZE     = 64,
  parameter int HISTORY_LINES = 10
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tle_in_if.sink     in_ch,
  tle_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata
);

  localparam int LW   = $clog2(LINE_SIZE);
  localparam int PW   = $clog2(HISTORY_LINES + 1);
  localparam int SW   = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
  localparam int HD   = HISTORY_LINES * LINE_SIZE;
  localparam int HAW  = $clog2(HD);
  localparam int SUMW = PW + 1;

  localparam logic [1:0] ESC_NORMAL  = 2'd0;
  localparam logic [1:0] ESC_SEEN    = 2'd1;
  localparam logic [1:0] ESC_BRACKET = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SHIFT = 7'b0000010,
    S_RIGHT = 7'b0000100,
    S_COPY  = 7'b0001000,
    S_DRD   = 7'b0010000,
    S_DWR   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    K_NONE, K_EXIT, K_LEFT, K_RIGHT, K_RECALL, K_ERASE_END, K_ERASE_MID,
    K_LINE_END, K_OVER, K_APPEND, K_INSERT
  } kind_t;

  state_t              state_r;
  logic [LW-1:0]       count_r, cursor_r, pos_r, src_r, dst_r, rem_r, pipe_dst_r;
  logic [1:0]          esc_r;
  logic [7:0]          prev_r;
  logic [PW-1:0]       used_r, hptr_r;
  logic [SW-1:0]       base_r, slot_r;
  logic [LW-1:0]       lens_r [HISTORY_LINES];
  logic                echo_r, pipe_v_r, ins_r, up_r;
  logic [3:0]          pend_act_r;
  logic [7:0]          pend_char_r;
  logic                pend_echo_r;

  logic                out_v_r, out_echo_r, out_last_r;
  logic [3:0]          out_act_r;
  logic [7:0]          out_char_r;
  logic [tle_pkg::POS_W-1:0] out_cur_r, out_len_r;

  // RAM ports.
  logic                line_we, line_re, hist_we, hist_re;
  logic [LW-1:0]       line_waddr, line_raddr;
  logic [7:0]          line_wdata, line_rdata, hist_rdata;
  logic [HAW-1:0]      hist_waddr, hist_raddr;

  logic                loadable, acc;
  logic [7:0]          b;
  kind_t               kind;
  logic [1:0]          esc_nxt;
  logic [PW-1:0]       hptr_nxt;
  logic [LW-1:0]       cur_c;
  logic [SW-1:0]       phys, push_slot;
  logic [SUMW-1:0]     sum_h, sum_p;

  logic                ld, ld_echo, ld_last;
  logic [3:0]          ld_act;
  logic [7:0]          ld_char;
  logic [LW-1:0]       ld_cur, ld_len;

  function automatic logic [HAW-1:0] haddr(input logic [SW-1:0] s, input logic [LW-1:0] i);
    haddr = HAW'(HAW'(s) * HAW'(LINE_SIZE) + HAW'(i));
  endfunction

  tle_ram #(.WIDTH(8), .DEPTH(LINE_SIZE)) u_line_ram (
    .clk(clk), .we(line_we), .waddr(line_waddr), .wdata(line_wdata),
    .re(line_re), .raddr(line_raddr), .rdata(line_rdata)
  );

  tle_ram #(.WIDTH(8), .DEPTH(HD)) u_hist_ram (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(line_rdata),
    .re(hist_re), .raddr(hist_raddr), .rdata(hist_rdata)
  );

  // Handshake: a new byte is taken only when idle and the result slot can load.
  assign loadable     = !out_v_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && loadable;
  assign acc          = in_ch.valid && in_ch.ready;
  assign b            = in_ch.rx_char;

  assign out_ch.valid       = out_v_r;
  assign out_ch.action      = out_act_r;
  assign out_ch.char_value  = out_char_r;
  assign out_ch.cursor_pos  = out_cur_r;
  assign out_ch.line_length = out_len_r;
  assign out_ch.echo_flag   = out_echo_r;
  assign out_ch.last_flag   = out_last_r;

  // Byte decode against the current escape phase and edit state.
  always_comb begin
    kind     = K_NONE;
    esc_nxt  = esc_r;
    hptr_nxt = hptr_r;
    cur_c    = (cursor_r > count_r) ? count_r : cursor_r;
    if (b == tle_pkg::CH_EXIT) begin
      kind = K_EXIT;
    end else if (prev_r == tle_pkg::CH_CR && b == tle_pkg::CH_NUL) begin
      kind = K_NONE;
    end else if (b == tle_pkg::CH_ESC) begin
      esc_nxt = ESC_SEEN;
    end else if (esc_r == ESC_SEEN && b == tle_pkg::CH_BRACKET) begin
      esc_nxt = ESC_BRACKET;
    end else if (esc_r == ESC_BRACKET && b >= tle_pkg::CH_UP && b <= tle_pkg::CH_LEFT) begin
      esc_nxt = ESC_NORMAL;
      case (b)
        tle_pkg::CH_UP: begin
          if (hptr_r != '0 && used_r != '0) begin
            kind     = K_RECALL;
            hptr_nxt = hptr_r - 1'b1;
          end
        end
        tle_pkg::CH_DOWN: begin
          if (used_r != '0) begin
            kind     = K_RECALL;
            hptr_nxt = (SUMW'(hptr_r) + 1'b1 < SUMW'(used_r)) ? hptr_r + 1'b1
                                                              : used_r - 1'b1;
          end
        end
        tle_pkg::CH_LEFT: begin
          if (cursor_r != '0) kind = K_LEFT;
        end
        default: begin
          if (cursor_r < count_r) kind = K_RIGHT;
        end
      endcase
    end else begin
      esc_nxt = ESC_NORMAL;
      case (b)
        tle_pkg::CH_TAB: kind = K_NONE;
        tle_pkg::CH_BS, tle_pkg::CH_DEL: begin
          if (cursor_r != '0 && count_r != '0) begin
            kind = (count_r > cursor_r) ? K_ERASE_MID : K_ERASE_END;
          end
        end
        tle_pkg::CH_CR, tle_pkg::CH_LF: kind = K_LINE_END;
        default: begin
          if (count_r == LW'(LINE_SIZE - 1)) kind = K_OVER;
          else if (cur_c < count_r)          kind = K_INSERT;
          else                               kind = K_APPEND;
        end
      endcase
    end
  end

  // Physical history slots: logical index counts from the oldest line at base_r.
  always_comb begin
    sum_h = SUMW'(base_r) + ((hptr_nxt >= PW'(HISTORY_LINES))
                             ? SUMW'(HISTORY_LINES - 1) : SUMW'(hptr_nxt));
    if (sum_h >= SUMW'(HISTORY_LINES)) sum_h = sum_h - SUMW'(HISTORY_LINES);
    phys = SW'(sum_h);
    if (used_r >= PW'(HISTORY_LINES)) begin
      sum_p = SUMW'(base_r);
    end else begin
      sum_p = SUMW'(base_r) + SUMW'(used_r);
      if (sum_p >= SUMW'(HISTORY_LINES)) sum_p = sum_p - SUMW'(HISTORY_LINES);
    end
    push_slot = SW'(sum_p);
  end

  // RAM control for each state.
  always_comb begin
    line_we    = 1'b0;
    line_waddr = pipe_dst_r;
    line_wdata = line_rdata;
    line_re    = 1'b0;
    line_raddr = src_r;
    hist_we    = 1'b0;
    hist_waddr = haddr(slot_r, src_r);
    hist_re    = 1'b0;
    hist_raddr = haddr(slot_r, src_r);
    unique case (state_r)
      S_IDLE: begin
        if (acc && kind == K_APPEND) begin
          line_we    = 1'b1;
          line_waddr = cur_c;
          line_wdata = b;
        end
        if (acc && kind == K_RIGHT) begin
          line_re    = 1'b1;
          line_raddr = cursor_r;
        end
      end
      S_SHIFT: begin
        line_re = (rem_r != '0);
        if (pipe_v_r) begin
          line_we = 1'b1;
        end else if (rem_r == '0 && ins_r) begin
          line_we    = 1'b1;
          line_waddr = pos_r;
          line_wdata = pend_char_r;
        end
      end
      S_COPY: begin
        hist_re    = (rem_r != '0);
        line_we    = pipe_v_r;
        line_wdata = hist_rdata;
      end
      S_DRD:   line_re = 1'b1;
      S_DWR:   hist_we = loadable;
      S_RIGHT, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Result load into the output register.
  always_comb begin
    ld      = 1'b0;
    ld_act  = tle_pkg::ACT_NONE;
    ld_char = '0;
    ld_cur  = cursor_r;
    ld_len  = count_r;
    ld_echo = 1'b0;
    ld_last = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          ld = 1'b1;
          case (kind)
            K_EXIT: ld_act = tle_pkg::ACT_EXIT;
            K_LEFT: begin
              ld_act = tle_pkg::ACT_LEFT;
              ld_cur = cursor_r - 1'b1;
            end
            K_ERASE_END: begin
              ld_act = tle_pkg::ACT_ERASE_END;
              ld_cur = cursor_r - 1'b1;
              ld_len = count_r - 1'b1;
            end
            K_LINE_END: begin
              ld     = (count_r == '0);
              ld_act = tle_pkg::ACT_COMPLETE;
              ld_cur = '0;
              ld_len = '0;
            end
            K_OVER: begin
              ld_act  = tle_pkg::ACT_OVERFLOW;
              ld_char = b;
              ld_cur  = '0;
              ld_len  = '0;
            end
            K_APPEND: begin
              ld_act  = tle_pkg::ACT_APPEND;
              ld_char = b;
              ld_cur  = cur_c + 1'b1;
              ld_len  = count_r + 1'b1;
              ld_echo = echo_r;
            end
            K_RIGHT, K_RECALL, K_ERASE_MID, K_INSERT: ld = 1'b0;
            default: ld_act = tle_pkg::ACT_NONE;
          endcase
        end
      end
      S_DWR: begin
        ld      = loadable;
        ld_act  = tle_pkg::ACT_LINE_CHAR;
        ld_char = line_rdata;
        ld_cur  = src_r;
        ld_last = 1'b0;
      end
      S_DONE: begin
        ld      = loadable;
        ld_act  = pend_act_r;
        ld_char = pend_char_r;
        ld_echo = pend_echo_r;
      end
      S_SHIFT, S_RIGHT, S_COPY, S_DRD: ld = 1'b0;
      default: ld = 1'b0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ld) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
    if (ld) begin
      out_act_r  <= ld_act;
      out_char_r <= ld_char;
      out_cur_r  <= tle_pkg::POS_W'(ld_cur);
      out_len_r  <= tle_pkg::POS_W'(ld_len);
      out_echo_r <= ld_echo;
      out_last_r <= ld_last;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r <= 1'b1;
    end else if (cfg_we) begin
      echo_r <= cfg_wdata;
    end
  end

  // Editor sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      cursor_r <= '0;
      esc_r    <= ESC_NORMAL;
      prev_r   <= '0;
      used_r   <= '0;
      hptr_r   <= '0;
      base_r   <= '0;
      pipe_v_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            prev_r      <= b;
            esc_r       <= esc_nxt;
            pipe_v_r    <= 1'b0;
            ins_r       <= 1'b0;
            pend_char_r <= '0;
            pend_echo_r <= 1'b0;
            case (kind)
              K_LEFT: cursor_r <= cursor_r - 1'b1;
              K_RIGHT: begin
                cursor_r   <= cursor_r + 1'b1;
                pend_act_r <= tle_pkg::ACT_RIGHT;
                state_r    <= S_RIGHT;
              end
              K_RECALL: begin
                hptr_r     <= hptr_nxt;
                slot_r     <= phys;
                count_r    <= lens_r[phys];
                cursor_r   <= lens_r[phys];
                src_r      <= '0;
                dst_r      <= '0;
                rem_r      <= lens_r[phys];
                up_r       <= 1'b1;
                pend_act_r <= tle_pkg::ACT_RECALL;
                state_r    <= S_COPY;
              end
              K_ERASE_END: begin
                count_r  <= count_r - 1'b1;
                cursor_r <= cursor_r - 1'b1;
              end
              K_ERASE_MID: begin
                count_r    <= count_r - 1'b1;
                cursor_r   <= cursor_r - 1'b1;
                src_r      <= cursor_r;
                dst_r      <= cursor_r - 1'b1;
                rem_r      <= count_r - cursor_r;
                up_r       <= 1'b1;
                pend_act_r <= tle_pkg::ACT_ERASE_MID;
                state_r    <= S_SHIFT;
              end
              K_LINE_END: begin
                if (count_r == '0) begin
                  hptr_r <= used_r;
                end else begin
                  slot_r         <= push_slot;
                  lens_r[push_slot] <= count_r;
                  src_r          <= '0;
                  state_r        <= S_DRD;
                  if (used_r >= PW'(HISTORY_LINES)) begin
                    base_r <= (base_r == SW'(HISTORY_LINES - 1)) ? '0 : base_r + 1'b1;
                    hptr_r <= used_r;
                  end else begin
                    used_r <= used_r + 1'b1;
                    hptr_r <= used_r + 1'b1;
                  end
                end
              end
              K_OVER: begin
                count_r  <= '0;
                cursor_r <= '0;
              end
              K_APPEND: begin
                count_r  <= count_r + 1'b1;
                cursor_r <= cur_c + 1'b1;
              end
              K_INSERT: begin
                pos_r       <= cur_c;
                cursor_r    <= cur_c + 1'b1;
                count_r     <= count_r + 1'b1;
                src_r       <= count_r - 1'b1;
                dst_r       <= count_r;
                rem_r       <= count_r - cur_c;
                up_r        <= 1'b0;
                ins_r       <= 1'b1;
                pend_char_r <= b;
                pend_echo_r <= echo_r;
                pend_act_r  <= tle_pkg::ACT_INSERT_MID;
                state_r     <= S_SHIFT;
              end
              default: begin
              end
            endcase
          end
        end
        // Byte move engine: one read issued and one write retired per cycle.
        S_SHIFT, S_COPY: begin
          if (rem_r != '0) begin
            src_r      <= up_r ? src_r + 1'b1 : src_r - 1'b1;
            dst_r      <= up_r ? dst_r + 1'b1 : dst_r - 1'b1;
            rem_r      <= rem_r - 1'b1;
            pipe_dst_r <= dst_r;
            pipe_v_r   <= 1'b1;
          end else begin
            pipe_v_r <= 1'b0;
            if (!pipe_v_r) state_r <= S_DONE;
          end
        end
        S_RIGHT: begin
          pend_char_r <= line_rdata;
          state_r     <= S_DONE;
        end
        S_DRD: state_r <= S_DWR;
        // Deliver one line character and copy it into history.
        S_DWR: begin
          if (loadable) begin
            src_r <= src_r + 1'b1;
            if ((LW + 1)'(src_r) + 1'b1 == (LW + 1)'(count_r)) begin
              count_r    <= '0;
              cursor_r   <= '0;
              pend_act_r <= tle_pkg::ACT_COMPLETE;
              state_r    <= S_DONE;
            end else begin
              state_r <= S_DRD;
            end
          end
        end
        S_DONE: begin
          if (loadable) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The cursor never passes the end of the line once an edit has finished.
  a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> cursor_r <= count_r)
    else $error("cursor beyond line end");

  // The history pointer stays within the used history.
  a_hptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    hptr_r <= used_r && used_r <= PW'(HISTORY_LINES))
    else $error("history pointer out of range");

  // An exit byte gives a single final exit result in the next cycle.
  a_exit_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && b == tle_pkg::CH_EXIT |=>
      out_v_r && out_act_r == tle_pkg::ACT_EXIT && out_last_r)
    else $error("exit byte without exit result");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the terminal line editor with history.
// Depends on tle_pkg, tle_ifs and terminal_line_editor_with_history.
`default_nettype none

module tb_top;

  localparam int LINE_MAX = 64;
  localparam int HIST_MAX = 10;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] char_value;
    logic [5:0] cursor_pos;
    logic [5:0] line_length;
    logic       echo_flag;
    logic       last_flag;
  } edit_result_t;

  typedef struct {
    logic [7:0]   ch;
    bit           typed;
    edit_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  tle_in_if  in_ch ();
  tle_out_if out_ch ();

  terminal_line_editor_with_history i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Editor state as the checker sees it.
  logic [7:0] ed_line [LINE_MAX];
  int unsigned ed_count, ed_cursor, ed_esc;
  logic [7:0] ed_prev;
  logic [7:0] ed_hist [HIST_MAX][LINE_MAX];
  int unsigned ed_hlen [HIST_MAX];
  int unsigned ed_used, ed_ptr;
  bit ed_echo;

  edit_result_t expected_q[$];
  int fail_count = 0;
  int results_seen = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int idle_cycles = 0;

  function automatic edit_result_t mk(logic [3:0] a, logic [7:0] c, int unsigned cur,
                                      int unsigned len, bit echo);
    edit_result_t r;
    r.action = a; r.char_value = c; r.cursor_pos = cur[5:0];
    r.line_length = len[5:0]; r.echo_flag = echo; r.last_flag = 1'b0;
    return r;
  endfunction

  task automatic load_history_line();
    int unsigned idx;
    int unsigned len;
    idx = (ed_ptr >= HIST_MAX) ? HIST_MAX - 1 : ed_ptr;
    len = ed_hlen[idx];
    if (len > LINE_MAX - 1) len = LINE_MAX - 1;
    for (int k = 0; k < LINE_MAX; k++) ed_line[k] = ed_hist[idx][k];
    ed_count = len;
    ed_cursor = len;
  endtask

  task automatic store_history_line();
    int unsigned slot;
    if (ed_count != 0) begin
      if (ed_used >= HIST_MAX) begin
        for (int h = 0; h < HIST_MAX - 1; h++) begin
          ed_hist[h] = ed_hist[h + 1];
          ed_hlen[h] = ed_hlen[h + 1];
        end
        slot = HIST_MAX - 1;
        ed_used = HIST_MAX;
      end else begin
        slot = ed_used;
        ed_used++;
      end
      for (int k = 0; k < LINE_MAX; k++)
        ed_hist[slot][k] = (k < ed_count) ? ed_line[k] : 8'h00;
      ed_hlen[slot] = ed_count;
    end
    ed_ptr = ed_used;
  endtask

  // Work out the results of one received byte and return them.
  task automatic edit_byte(input logic [7:0] b, output edit_result_t res[$]);
    logic [7:0] prev;
    int unsigned len;
    logic [3:0] act;
    res = {};
    prev = ed_prev;
    ed_prev = b;
    if (b == tle_pkg::CH_EXIT) begin
      res.push_back(mk(tle_pkg::ACT_EXIT, 0, ed_cursor, ed_count, 0));
    end else if (prev == tle_pkg::CH_CR && b == tle_pkg::CH_NUL) begin
      res.push_back(mk(tle_pkg::ACT_NONE, 0, ed_cursor, ed_count, 0));
    end else if (b == tle_pkg::CH_ESC) begin
      ed_esc = 1;
      res.push_back(mk(tle_pkg::ACT_NONE, 0, ed_cursor, ed_count, 0));
    end else if (ed_esc == 1 && b == tle_pkg::CH_BRACKET) begin
      ed_esc = 2;
      res.push_back(mk(tle_pkg::ACT_NONE, 0, ed_cursor, ed_count, 0));
    end else if (ed_esc == 2 && b >= tle_pkg::CH_UP && b <= tle_pkg::CH_LEFT) begin
      ed_esc = 0;
      if (b == tle_pkg::CH_UP) begin
        if (ed_ptr > 0 && ed_used != 0) begin
          ed_ptr--;
          load_history_line();
          res.push_back(mk(tle_pkg::ACT_RECALL, 0, ed_cursor, ed_count, 0));
        end
      end else if (b == tle_pkg::CH_DOWN) begin
        if (ed_used != 0) begin
          if (ed_ptr + 1 < ed_used) ed_ptr++;
          else ed_ptr = ed_used - 1;
          load_history_line();
          res.push_back(mk(tle_pkg::ACT_RECALL, 0, ed_cursor, ed_count, 0));
        end
      end else if (b == tle_pkg::CH_LEFT) begin
        if (ed_cursor > 0) begin
          ed_cursor--;
          res.push_back(mk(tle_pkg::ACT_LEFT, 0, ed_cursor, ed_count, 0));
        end
      end else begin
        if (ed_cursor < ed_count && ed_cursor < LINE_MAX) begin
          ed_cursor++;
          res.push_back(mk(tle_pkg::ACT_RIGHT, ed_line[ed_cursor - 1], ed_cursor,
                           ed_count, 0));
        end
      end
      if (res.size() == 0)
        res.push_back(mk(tle_pkg::ACT_NONE, 0, ed_cursor, ed_count, 0));
    end else begin
      ed_esc = 0;
      if (b == tle_pkg::CH_TAB) begin
        res.push_back(mk(tle_pkg::ACT_NONE, 0, ed_cursor, ed_count, 0));
      end else if (b == tle_pkg::CH_DEL || b == tle_pkg::CH_BS) begin
        if (ed_cursor == 0 || ed_count == 0) begin
          res.push_back(mk(tle_pkg::ACT_NONE, 0, ed_cursor, ed_count, 0));
        end else begin
          ed_count--;
          ed_cursor--;
          if (ed_count > ed_cursor) begin
            for (int unsigned k = ed_cursor; k < ed_count; k++) ed_line[k] = ed_line[k + 1];
            res.push_back(mk(tle_pkg::ACT_ERASE_MID, 0, ed_cursor, ed_count, 0));
          end else begin
            res.push_back(mk(tle_pkg::ACT_ERASE_END, 0, ed_cursor, ed_count, 0));
          end
        end
      end else if (b == tle_pkg::CH_CR || b == tle_pkg::CH_LF) begin
        len = ed_count;
        store_history_line();
        for (int unsigned k = 0; k < len && k < LINE_MAX; k++)
          res.push_back(mk(tle_pkg::ACT_LINE_CHAR, ed_line[k], k, len, 0));
        ed_count = 0;
        ed_cursor = 0;
        for (int k = 0; k < LINE_MAX; k++) ed_line[k] = 8'h00;
        res.push_back(mk(tle_pkg::ACT_COMPLETE, 0, 0, 0, 0));
      end else begin
        if (ed_cursor > ed_count) ed_cursor = ed_count;
        if (ed_cursor < ed_count) begin
          for (int unsigned k = ed_count; k > ed_cursor; k--) ed_line[k] = ed_line[k - 1];
          act = tle_pkg::ACT_INSERT_MID;
        end else begin
          act = tle_pkg::ACT_APPEND;
        end
        ed_line[ed_cursor] = b;
        ed_count++;
        ed_cursor++;
        if (ed_count >= LINE_MAX) begin
          ed_count = 0;
          ed_cursor = 0;
          res.push_back(mk(tle_pkg::ACT_OVERFLOW, b, 0, 0, 0));
        end else begin
          res.push_back(mk(act, b, ed_cursor, ed_count, ed_echo));
        end
      end
    end
    res[res.size() - 1].last_flag = 1'b1;
  endtask

  task automatic reset_editor_model();
    for (int k = 0; k < LINE_MAX; k++) ed_line[k] = 8'h00;
    for (int h = 0; h < HIST_MAX; h++) begin
      ed_hlen[h] = 0;
      for (int k = 0; k < LINE_MAX; k++) ed_hist[h][k] = 8'h00;
    end
    ed_count = 0; ed_cursor = 0; ed_esc = 0; ed_prev = 8'h00;
    ed_used = 0; ed_ptr = 0; ed_echo = 1'b1;
  endtask

  // Compare a result against the oldest expectation.
  task automatic check_result(input edit_result_t got);
    edit_result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: action %0d", got.action);
      fail_count++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.action !== exp_r.action) begin
      $error("action: expected %0d, got %0d", exp_r.action, got.action); fail_count++;
    end
    if (got.char_value !== exp_r.char_value) begin
      $error("char_value: expected %0h, got %0h", exp_r.char_value, got.char_value);
      fail_count++;
    end
    if (got.cursor_pos !== exp_r.cursor_pos) begin
      $error("cursor_pos: expected %0d, got %0d", exp_r.cursor_pos, got.cursor_pos);
      fail_count++;
    end
    if (got.line_length !== exp_r.line_length) begin
      $error("line_length: expected %0d, got %0d", exp_r.line_length, got.line_length);
      fail_count++;
    end
    if (got.echo_flag !== exp_r.echo_flag) begin
      $error("echo_flag: expected %0b, got %0b", exp_r.echo_flag, got.echo_flag);
      fail_count++;
    end
    if (got.last_flag !== exp_r.last_flag) begin
      $error("last_flag: expected %0b, got %0b", exp_r.last_flag, got.last_flag);
      fail_count++;
    end
    results_seen++;
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    edit_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.action = out_ch.action; got.char_value = out_ch.char_value;
      got.cursor_pos = out_ch.cursor_pos; got.line_length = out_ch.line_length;
      got.echo_flag = out_ch.echo_flag; got.last_flag = out_ch.last_flag;
      check_result(got);
    end
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no request moving on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one byte and wait for its acceptance; a typed row is also
  // checked against the predictor. The request stays offered after its
  // acceptance until the next call or stop_sending takes it down.
  task automatic send_byte(input logic [7:0] b, input bit typed = 0,
                           input edit_result_t want = '0);
    edit_result_t res[$];
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    edit_byte(b, res);
    if (typed && res[0] !== want) begin
      $error("rx_char %0h: typed result %0h, predicted %0h", b, want, res[0]);
      fail_count++;
    end
    foreach (res[k]) expected_q.push_back(res[k]);
    in_ch.valid <= 1'b1;
    in_ch.rx_char <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_echo(input bit v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ed_echo = v;
  endtask

  // Mostly printable text, with editing keys, line ends, tab, exit, NUL and random bytes.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 8'($urandom_range(8'h20, 8'h7e));
    if (r < 63) return tle_pkg::CH_DEL;
    if (r < 66) return tle_pkg::CH_BS;
    if (r < 72) return tle_pkg::CH_CR;
    if (r < 74) return tle_pkg::CH_LF;
    if (r < 76) return tle_pkg::CH_TAB;
    if (r < 77) return tle_pkg::CH_EXIT;
    if (r < 80) return tle_pkg::CH_NUL;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_arrow(input logic [7:0] key);
    send_byte(tle_pkg::CH_ESC);
    send_byte(tle_pkg::CH_BRACKET);
    send_byte(key);
  endtask

  task automatic random_phase(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 25) begin
        case ($urandom_range(3))
          0: send_arrow(tle_pkg::CH_UP);
          1: send_arrow(tle_pkg::CH_DOWN);
          2: send_arrow(tle_pkg::CH_LEFT);
          default: send_arrow(tle_pkg::CH_RIGHT);
        endcase
      end else if (r < 30) begin
        send_byte(tle_pkg::CH_ESC);
        send_byte(pick_byte());
      end else begin
        send_byte(pick_byte());
      end
    end
  endtask

  stim_row_t directed[$];

  function automatic stim_row_t row(logic [7:0] ch, bit typed = 0,
                                    edit_result_t res = '0);
    stim_row_t s;
    s.ch = ch; s.typed = typed; s.res = res;
    return s;
  endfunction

  initial begin
    edit_result_t want;
    reset_editor_model();
    in_ch.valid = 1'b0;
    in_ch.rx_char = 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Edge cases first on an empty editor, then edits of a short line.
    want = mk(tle_pkg::ACT_NONE, 0, 0, 0, 0); want.last_flag = 1;
    directed.push_back(row(tle_pkg::CH_DEL, 1, want));
    directed.push_back(row(tle_pkg::CH_TAB, 1, want));
    want = mk(tle_pkg::ACT_EXIT, 0, 0, 0, 0); want.last_flag = 1;
    directed.push_back(row(tle_pkg::CH_EXIT, 1, want));
    want = mk(tle_pkg::ACT_COMPLETE, 0, 0, 0, 0); want.last_flag = 1;
    directed.push_back(row(tle_pkg::CH_CR, 1, want));
    want = mk(tle_pkg::ACT_NONE, 0, 0, 0, 0); want.last_flag = 1;
    directed.push_back(row(tle_pkg::CH_NUL, 1, want));
    want = mk(tle_pkg::ACT_APPEND, 8'hff, 1, 1, 1); want.last_flag = 1;
    directed.push_back(row(8'hff, 1, want));
    directed.push_back(row(8'h01));
    directed.push_back(row(8'h61));
    directed.push_back(row(tle_pkg::CH_ESC)); directed.push_back(row(tle_pkg::CH_BRACKET));
    directed.push_back(row(tle_pkg::CH_LEFT));
    directed.push_back(row(8'h80));
    directed.push_back(row(tle_pkg::CH_ESC)); directed.push_back(row(tle_pkg::CH_BRACKET));
    directed.push_back(row(tle_pkg::CH_RIGHT));
    directed.push_back(row(tle_pkg::CH_ESC)); directed.push_back(row(8'h7a));
    directed.push_back(row(tle_pkg::CH_BS));
    directed.push_back(row(tle_pkg::CH_LF));
    directed.push_back(row(tle_pkg::CH_ESC)); directed.push_back(row(tle_pkg::CH_BRACKET));
    directed.push_back(row(tle_pkg::CH_UP));
    directed.push_back(row(tle_pkg::CH_CR));
    foreach (directed[k]) send_byte(directed[k].ch, directed[k].typed, directed[k].res);

    // Overflow: the last of these bytes arrives on a full line and overflows it.
    for (int k = 0; k < LINE_MAX; k++) send_byte(8'($urandom_range(8'h20, 8'h7e)));
    // Fill the history past its depth, reload the newest, walk up past the
    // oldest and come back down once.
    for (int h = 0; h < HIST_MAX + 1; h++) begin
      send_byte(8'h41 + 8'(h));
      send_byte(tle_pkg::CH_CR);
    end
    send_arrow(tle_pkg::CH_DOWN);
    repeat (HIST_MAX) send_arrow(tle_pkg::CH_UP);
    send_arrow(tle_pkg::CH_DOWN);
    send_byte(tle_pkg::CH_CR);

    // Receiver-heavy idling, echo off.
    write_echo(1'b0);
    send_idle_pct = 34; recv_idle_pct = 53;
    random_phase(12);
    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
      end
      begin
        random_phase(6);
        stop_sending();
      end
    join
    // Pause until every expected result has come, echo back on.
    write_echo(1'b1);
    send_idle_pct = 53; recv_idle_pct = 34;
    random_phase(12);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(8);

    drain();
    $display("Sent %0d bytes, checked %0d results over both echo settings,",
             bytes_sent, results_seen);
    $display("including overflow, history wrap, arrows and stalls.");
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* files.f */
rtl/tle_pkg.sv
rtl/tle_ifs.sv
rtl/tle_ram.sv
rtl/terminal_line_editor_with_history.sv
tb/sv/tb_top.sv
